// ===== rtl/pngchp_pkg.sv =====
package pngchp_pkg;

  // The eight bytes that open every PNG file.
  localparam logic [7:0] PNG_SIG [8] = '{
    8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10
  };

  // Result tags.
  localparam logic [4:0] TAG_WIDTH         = 5'd0;
  localparam logic [4:0] TAG_HEIGHT        = 5'd1;
  localparam logic [4:0] TAG_BIT_DEPTH     = 5'd2;
  localparam logic [4:0] TAG_GAMMA         = 5'd7;
  localparam logic [4:0] TAG_CHROMA        = 5'd8;
  localparam logic [4:0] TAG_BAD_LENGTH    = 5'd16;
  localparam logic [4:0] TAG_BAD_SIGNATURE = 5'd17;
  localparam logic [4:0] TAG_SUMMARY       = 5'd18;

  // Chunk type codes, big-endian ASCII.
  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_GAMA = 32'h6741_4D41;
  localparam logic [31:0] TYPE_CHRM = 32'h6348_524D;
  localparam logic [31:0] TYPE_SRGB = 32'h7352_4742;
  localparam logic [31:0] TYPE_ICCP = 32'h6943_4350;

  localparam logic [31:0] CHRM_LEN            = 32'd32;
  localparam logic [31:0] SRGB_LEN            = 32'd1;
  localparam logic [31:0] SRGB_GAMMA          = 32'd45455;
  localparam logic [31:0] DEFAULT_GAMMA_RESET = 32'd45455;

  // sRGB chromaticities in tag order: white, red, green, blue (x then y).
  localparam logic [31:0] SRGB_DEFAULTS [8] = '{
    32'd31270, 32'd32900, 32'd64000, 32'd33000,
    32'd30000, 32'd60000, 32'd15000, 32'd6000
  };

  // Chromaticity codes saturate to 17 bits for the gamut decision.
  localparam int unsigned CODE_BITS = 17;
  typedef logic [CODE_BITS-1:0] code_t;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_LEN,
    PH_TYPE,
    PH_DATA,
    PH_CRC,
    PH_BAD
  } phase_t;

  typedef enum logic [1:0] {
    DR_RUN,
    DR_DEFAULTS,
    DR_SUMMARY
  } drain_t;

  // One event from the byte parser.
  typedef struct packed {
    logic        valid;
    logic [4:0]  tag;
    logic [31:0] value;
  } event_t;

  // What the parser holds for the end-of-file summary.
  typedef struct packed {
    logic        sig_ok;
    logic        chrm;
    logic        srgb;
    logic        iccp;
    logic [31:0] gamma;
    code_t       red_x;
    code_t       red_y;
    code_t       green_x;
    code_t       green_y;
  } status_t;

  typedef struct packed {
    logic [4:0]  tag;
    logic [31:0] value;
    logic        file_valid;
    logic        is_p3;
    logic        has_chromaticity;
    logic        srgb_seen;
    logic        iccp_seen;
    logic [31:0] gamma_code;
    logic        last;
  } result_t;

endpackage

// ===== rtl/pngchp_byte_if.sv =====
interface pngchp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source(output valid, data_byte, end_of_file, input ready);
  modport sink(input valid, data_byte, end_of_file, output ready);
endinterface

// ===== rtl/pngchp_res_if.sv =====
interface pngchp_res_if;
  logic        valid;
  logic        ready;
  logic [4:0]  tag;
  logic [31:0] value;
  logic        file_valid;
  logic        is_p3;
  logic        has_chromaticity;
  logic        srgb_seen;
  logic        iccp_seen;
  logic [31:0] gamma_code;
  logic        last;

  modport source(output valid, tag, value, file_valid, is_p3, has_chromaticity,
                 srgb_seen, iccp_seen, gamma_code, last, input ready);
  modport sink(input valid, tag, value, file_valid, is_p3, has_chromaticity,
               srgb_seen, iccp_seen, gamma_code, last, output ready);
endinterface

// ===== rtl/pngchp_cfg_if.sv =====
interface pngchp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] default_gamma_code;

  modport source(output valid, default_gamma_code, input ready);
  modport sink(input valid, default_gamma_code, output ready);
endinterface

// ===== rtl/png_chunk_header_parser_unit.sv =====
// A byte's event is formed from the input register and leaves the result register.
// Throughput: one byte per cycle while results are taken as they appear.
// The end-of-file byte stalls input until any sRGB defaults and the summary are out.
// Reset (synchronous, active high) returns the parser to the signature phase,
// empties both registers and loads the default gamma code 45455.
module png_chunk_header_parser_unit (
  input logic           clk,
  input logic           rst,
  pngchp_byte_if.sink   bytes,
  pngchp_res_if.source  results,
  pngchp_cfg_if.sink    cfg
);
  import pngchp_pkg::*;

  // The configuration register is always writable; it is only sampled by
  // the parser at the first byte of a file and at restart.
  logic [31:0] default_gamma_code;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_gamma_code <= DEFAULT_GAMMA_RESET;
    end else if (cfg.valid) begin
      default_gamma_code <= cfg.default_gamma_code;
    end
  end

  // Input register. A new byte can be transferred in whenever the held one
  // is stepped in the same cycle. While a result waits in the result
  // register, the held byte stays put and the input stalls.
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_eof;

  // End-of-file sequencer and its control.
  drain_t     drain_state, drain_next;
  logic [2:0] def_idx;
  logic       slot_free;
  logic       step;
  logic       emit_default;
  logic       emit_summary;
  logic       restart;

  event_t     ev;
  status_t    status;

  logic       res_valid;
  result_t    res_q, res_d;
  logic       res_load;

  logic       has_chrm;
  logic       p3_closer;
  logic [24:0] rx_w, ry_w, gx_w, gy_w;
  logic [24:0] score;

  // The result register can take a new result when it is empty or when its
  // current result is being transferred out in this cycle.
  assign slot_free = !res_valid || results.ready;

  always_comb begin
    step         = in_full && drain_state == DR_RUN && slot_free;
    emit_default = drain_state == DR_DEFAULTS && status.srgb && slot_free;
    emit_summary = drain_state == DR_SUMMARY && slot_free;
    restart      = emit_summary;
  end

  // After the end-of-file byte has been stepped, its flags are registered;
  // the sequencer then emits the sRGB defaults if sRGB was seen, and then the
  // summary, and finally returns the parser to its start state.
  always_comb begin
    drain_next = drain_state;
    unique case (drain_state)
      DR_RUN: begin
        if (step && in_eof) begin
          drain_next = DR_DEFAULTS;
        end
      end
      DR_DEFAULTS: begin
        if (!status.srgb) begin
          drain_next = DR_SUMMARY;
        end else if (slot_free && def_idx == 3'd7) begin
          drain_next = DR_SUMMARY;
        end
      end
      DR_SUMMARY: begin
        if (slot_free) begin
          drain_next = DR_RUN;
        end
      end
      default: drain_next = DR_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drain_state <= DR_RUN;
      def_idx     <= '0;
    end else begin
      drain_state <= drain_next;
      if (emit_default) begin
        def_idx <= def_idx + 3'd1;
      end
    end
  end

  assign bytes.ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_byte <= bytes.data_byte;
      in_eof  <= bytes.end_of_file;
    end
  end

  pngchp_parse u_parse (
    .clk                (clk),
    .rst                (rst),
    .step               (step),
    .restart            (restart),
    .data_byte          (in_byte),
    .default_gamma_code (default_gamma_code),
    .ev                 (ev),
    .status             (status)
  );

  // Display P3 decision. The difference of the two summed squared distances
  // is linear in each code, because the reference points differ only in a
  // fixed offset: (v-s)^2 - (v-p)^2 = (p-s)(2v-p-s). Blue is the same point
  // in both spaces and drops out. Scaling by 1/1000 leaves
  // 8*rx - 2*ry - 7*gx + 18*gy > 1426250, built from shifts and adds.
  assign rx_w = {8'd0, status.red_x};
  assign ry_w = {8'd0, status.red_y};
  assign gx_w = {8'd0, status.green_x};
  assign gy_w = {8'd0, status.green_y};

  assign score = (rx_w << 3) - (ry_w << 1) - ((gx_w << 3) - gx_w)
               + (gy_w << 4) + (gy_w << 1);

  assign p3_closer = $signed(score) > $signed(25'd1426250);

  // Chromaticity only counts when no sRGB or iCCP chunk overrides it.
  assign has_chrm = status.chrm && !status.srgb && !status.iccp;

  always_comb begin
    res_d    = '0;
    res_load = 1'b0;
    if (step && ev.valid) begin
      res_load    = 1'b1;
      res_d.tag   = ev.tag;
      res_d.value = ev.value;
    end else if (emit_default) begin
      res_load    = 1'b1;
      res_d.tag   = TAG_CHROMA + {2'd0, def_idx};
      res_d.value = SRGB_DEFAULTS[def_idx];
    end else if (emit_summary) begin
      res_load               = 1'b1;
      res_d.tag              = TAG_SUMMARY;
      res_d.file_valid       = status.sig_ok;
      res_d.is_p3            = !has_chrm || p3_closer;
      res_d.has_chromaticity = has_chrm;
      res_d.srgb_seen        = status.srgb;
      res_d.iccp_seen        = status.iccp;
      res_d.gamma_code       = status.srgb ? SRGB_GAMMA : status.gamma;
      res_d.last             = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign results.valid            = res_valid;
  assign results.tag              = res_q.tag;
  assign results.value            = res_q.value;
  assign results.file_valid       = res_q.file_valid;
  assign results.is_p3            = res_q.is_p3;
  assign results.has_chromaticity = res_q.has_chromaticity;
  assign results.srgb_seen        = res_q.srgb_seen;
  assign results.iccp_seen        = res_q.iccp_seen;
  assign results.gamma_code       = res_q.gamma_code;
  assign results.last             = res_q.last;

endmodule

// ===== rtl/pngchp_parse.sv =====
module pngchp_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                restart,
  input  logic [7:0]          data_byte,
  input  logic [31:0]         default_gamma_code,
  output pngchp_pkg::event_t  ev,
  output pngchp_pkg::status_t status
);
  import pngchp_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] byte_counter, byte_counter_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] chunk_type, chunk_type_next;
  logic [31:0] shift_word, shift_word_next;
  logic [31:0] gamma_store, gamma_store_next;
  logic        sig_ok, sig_ok_next;
  logic        chrm, chrm_next;
  logic        srgb, srgb_next;
  logic        iccp, iccp_next;
  code_t       red_x, red_x_next;
  code_t       red_y, red_y_next;
  code_t       green_x, green_x_next;
  code_t       green_y, green_y_next;

  logic [31:0] shifted;
  logic [31:0] count_inc;
  logic        sig_match;
  logic        chrm_ok;
  logic        chrm_store;
  logic [2:0]  chrm_index;
  code_t       code_sat;
  logic        in_ihdr_bytes;

  assign shifted       = {shift_word[23:0], data_byte};
  assign count_inc     = byte_counter + 32'd1;
  assign sig_match     = data_byte == PNG_SIG[byte_counter[2:0]];
  assign chrm_ok       = chunk_type == TYPE_CHRM && chunk_length == CHRM_LEN;
  assign chrm_store    = chrm_ok && byte_counter[1:0] == 2'd3;
  assign chrm_index    = byte_counter[4:2];
  assign code_sat      = (|shifted[31:CODE_BITS]) ? '1 : shifted[CODE_BITS-1:0];
  assign in_ihdr_bytes = byte_counter >= 32'd8 && byte_counter <= 32'd12;

  always_comb begin
    phase_next        = phase;
    byte_counter_next = byte_counter;
    chunk_length_next = chunk_length;
    chunk_type_next   = chunk_type;
    shift_word_next   = shift_word;
    gamma_store_next  = gamma_store;
    sig_ok_next       = sig_ok;
    chrm_next         = chrm;
    srgb_next         = srgb;
    iccp_next         = iccp;
    red_x_next        = red_x;
    red_y_next        = red_y;
    green_x_next      = green_x;
    green_y_next      = green_y;

    if (restart) begin
      phase_next        = PH_SIG;
      byte_counter_next = '0;
      chunk_length_next = '0;
      chunk_type_next   = '0;
      shift_word_next   = '0;
      gamma_store_next  = default_gamma_code;
      sig_ok_next       = 1'b0;
      chrm_next         = 1'b0;
      srgb_next         = 1'b0;
      iccp_next         = 1'b0;
      red_x_next        = '0;
      red_y_next        = '0;
      green_x_next      = '0;
      green_y_next      = '0;
    end else if (step) begin
      shift_word_next = shifted;
      // The gamma falls back to the register at the first byte of a file.
      if (phase == PH_SIG && byte_counter == '0) begin
        gamma_store_next = default_gamma_code;
      end
      unique case (phase)
        PH_SIG: begin
          if (!sig_match) begin
            phase_next = PH_BAD;
          end else if (byte_counter[2:0] == 3'd7) begin
            sig_ok_next       = 1'b1;
            phase_next        = PH_LEN;
            byte_counter_next = '0;
          end else begin
            byte_counter_next = count_inc;
          end
        end
        PH_LEN: begin
          if (byte_counter[1:0] == 2'd3) begin
            chunk_length_next = shifted;
            phase_next        = PH_TYPE;
            byte_counter_next = '0;
          end else begin
            byte_counter_next = count_inc;
          end
        end
        PH_TYPE: begin
          if (byte_counter[1:0] == 2'd3) begin
            chunk_type_next   = shifted;
            byte_counter_next = '0;
            if (shifted == TYPE_SRGB && chunk_length == SRGB_LEN) begin
              srgb_next = 1'b1;
            end
            if (shifted == TYPE_ICCP) begin
              iccp_next = 1'b1;
            end
            phase_next = (chunk_length == '0) ? PH_CRC : PH_DATA;
          end else begin
            byte_counter_next = count_inc;
          end
        end
        PH_DATA: begin
          if (chunk_type == TYPE_GAMA && byte_counter == 32'd3) begin
            gamma_store_next = shifted;
          end
          if (chrm_store) begin
            case (chrm_index)
              3'd2:    red_x_next   = code_sat;
              3'd3:    red_y_next   = code_sat;
              3'd4:    green_x_next = code_sat;
              3'd5:    green_y_next = code_sat;
              3'd7:    chrm_next    = 1'b1;
              default: ;
            endcase
          end
          if (count_inc >= chunk_length) begin
            phase_next        = PH_CRC;
            byte_counter_next = '0;
          end else begin
            byte_counter_next = count_inc;
          end
        end
        PH_CRC: begin
          if (byte_counter[1:0] == 2'd3) begin
            phase_next        = PH_LEN;
            byte_counter_next = '0;
          end else begin
            byte_counter_next = count_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // Event for the byte being stepped; at most one per byte.
  always_comb begin
    ev = '0;
    if (step) begin
      unique case (phase)
        PH_SIG: begin
          if (!sig_match) begin
            ev.valid = 1'b1;
            ev.tag   = TAG_BAD_SIGNATURE;
            ev.value = {29'd0, byte_counter[2:0]};
          end
        end
        PH_TYPE: begin
          if (byte_counter[1:0] == 2'd3 &&
              ((shifted == TYPE_CHRM && chunk_length != CHRM_LEN) ||
               (shifted == TYPE_SRGB && chunk_length != SRGB_LEN))) begin
            ev.valid = 1'b1;
            ev.tag   = TAG_BAD_LENGTH;
            ev.value = chunk_length;
          end
        end
        PH_DATA: begin
          if (chunk_type == TYPE_IHDR) begin
            if (byte_counter == 32'd3) begin
              ev.valid = 1'b1;
              ev.tag   = TAG_WIDTH;
              ev.value = shifted;
            end else if (byte_counter == 32'd7) begin
              ev.valid = 1'b1;
              ev.tag   = TAG_HEIGHT;
              ev.value = shifted;
            end else if (in_ihdr_bytes) begin
              ev.valid = 1'b1;
              ev.tag   = TAG_BIT_DEPTH + {2'd0, byte_counter[2:0]};
              ev.value = {24'd0, data_byte};
            end
          end else if (chunk_type == TYPE_GAMA) begin
            if (byte_counter == 32'd3) begin
              ev.valid = 1'b1;
              ev.tag   = TAG_GAMMA;
              ev.value = shifted;
            end
          end else if (chrm_store) begin
            ev.valid = 1'b1;
            ev.tag   = TAG_CHROMA + {2'd0, chrm_index};
            ev.value = shifted;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SIG;
      byte_counter <= '0;
      chunk_length <= '0;
      chunk_type   <= '0;
      shift_word   <= '0;
      gamma_store  <= DEFAULT_GAMMA_RESET;
      sig_ok       <= 1'b0;
      chrm         <= 1'b0;
      srgb         <= 1'b0;
      iccp         <= 1'b0;
      red_x        <= '0;
      red_y        <= '0;
      green_x      <= '0;
      green_y      <= '0;
    end else begin
      phase        <= phase_next;
      byte_counter <= byte_counter_next;
      chunk_length <= chunk_length_next;
      chunk_type   <= chunk_type_next;
      shift_word   <= shift_word_next;
      gamma_store  <= gamma_store_next;
      sig_ok       <= sig_ok_next;
      chrm         <= chrm_next;
      srgb         <= srgb_next;
      iccp         <= iccp_next;
      red_x        <= red_x_next;
      red_y        <= red_y_next;
      green_x      <= green_x_next;
      green_y      <= green_y_next;
    end
  end

  assign status = '{
    sig_ok:  sig_ok,
    chrm:    chrm,
    srgb:    srgb,
    iccp:    iccp,
    gamma:   gamma_store,
    red_x:   red_x,
    red_y:   red_y,
    green_x: green_x,
    green_y: green_y
  };

endmodule
